// ===== hdl/min_makespan_job_assignment_top_defines.svh =====
// Assertion macros for the min-makespan job assignment block.
// Used by the top level only; no other dependencies.
`ifndef MIN_MAKESPAN_JOB_ASSIGNMENT_TOP_DEFINES_SVH
`define MIN_MAKESPAN_JOB_ASSIGNMENT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MMJA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MMJA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MMJA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MMJA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/mmja_pkg.sv =====
// Package for the min-makespan job assignment block: sizes and command types.
// No dependencies.
`default_nettype none
package mmja_pkg;
   localparam int MaxJobs    = 16;
   localparam int MaxWorkers = 16;
   localparam int JobBits    = 24;
   localparam int OutBits    = 28;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SORT,
      CMD_INIT,
      CMD_STEP,
      CMD_EMIT
   } cmd_type;

   typedef struct packed {
      logic sort_done;
      logic search_done;
   } status_type;
endpackage
`default_nettype wire

// ===== hdl/mmja_ctrl.sv =====
// Controller for the min-makespan job assignment block.
// Depends on mmja_pkg.
`default_nettype none
module mmja_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_last_job,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire mmja_pkg::status_type status,
   output mmja_pkg::cmd_type      cmd
);
   typedef enum logic [2:0] {S_LOAD, S_SORT, S_INIT, S_SEARCH, S_OUT} state_type;
   state_type state_ff;
   logic      rsp_valid_ff;
   logic      emit;

   // A new batch may load while the previous result still waits.
   assign req_stall = !(state_ff == S_LOAD);
   assign rsp_valid = rsp_valid_ff;

   // The result register is loaded only once the previous result has left.
   assign emit = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      unique case (state_ff)
         S_LOAD:   cmd = (req_valid) ? mmja_pkg::CMD_LOAD : mmja_pkg::CMD_NONE;
         S_SORT:   cmd = mmja_pkg::CMD_SORT;
         S_INIT:   cmd = mmja_pkg::CMD_INIT;
         S_SEARCH: cmd = mmja_pkg::CMD_STEP;
         default:  cmd = (emit) ? mmja_pkg::CMD_EMIT : mmja_pkg::CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            S_LOAD:   if (req_valid && req_last_job) state_ff <= S_SORT;
            S_SORT:   if (status.sort_done) state_ff <= S_INIT;
            S_INIT:   state_ff <= S_SEARCH;
            S_SEARCH: if (status.search_done) state_ff <= S_OUT;
            default:  if (emit) state_ff <= S_LOAD;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== hdl/mmja_dp.sv =====
// Datapath for the min-makespan job assignment block: job store, sort, search.
// Depends on mmja_pkg.
`default_nettype none
module mmja_dp #(
   parameter int MAX_JOBS    = mmja_pkg::MaxJobs,
   parameter int MAX_WORKERS = mmja_pkg::MaxWorkers,
   parameter int JOB_BITS    = mmja_pkg::JobBits
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mmja_pkg::cmd_type           cmd,
   input  wire logic [JOB_BITS-1:0]         job_in,
   input  wire logic [4:0]                  workers,
   output mmja_pkg::status_type             status,
   output logic [mmja_pkg::OutBits-1:0]     result,
   output logic                             overflow
);
   localparam int JW = $clog2(MAX_JOBS + 1);
   localparam int JI = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int WW = $clog2(MAX_WORKERS + 1);
   localparam int WI = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int LW = JOB_BITS + JW;
   localparam int OB = mmja_pkg::OutBits;

   logic [JOB_BITS-1:0] jobs_ff [MAX_JOBS];
   logic [LW-1:0]       loads_ff [MAX_WORKERS];
   logic [WW-1:0]       choice_ff [MAX_JOBS];
   logic [WW-1:0]       used_ff [MAX_JOBS+1];
   logic [LW-1:0]       max_ff [MAX_JOBS+1];
   logic [JW-1:0]       count_ff, depth_ff, pass_ff;
   logic [LW:0]         best_ff;
   logic                enter_ff, ovf_ff, done_ff, sdone_ff;
   logic [OB-1:0]       result_ff;
   logic                overflow_ff;
   logic [WW-1:0]       wcnt;

   always_comb begin
      if (workers == 5'd0) wcnt = WW'(1);
      else if (32'(workers) > MAX_WORKERS) wcnt = WW'(MAX_WORKERS);
      else wcnt = WW'(workers);
   end

   // Search step decode.
   logic [JI-1:0]       di;
   logic                at_leaf, cut, retreat, same_n, done_in;
   logic [WW:0]         cnext;
   logic [JI-1:0]       bi;
   logic [WW-1:0]       bc, bu;
   logic [WI-1:0]       bwk, fwk;
   logic [LW-1:0]       fload;
   always_comb begin
      di      = JI'(depth_ff);
      at_leaf = (depth_ff == count_ff);
      cut     = ({1'b0, max_ff[depth_ff]} >= best_ff) || at_leaf;
      if (enter_ff) cnext = '0;
      else cnext = {1'b0, choice_ff[di]} + 1'b1;
      if (cnext == '0 && used_ff[depth_ff] >= wcnt) cnext = (WW+1)'(1);
      retreat = enter_ff ? cut : 1'b0;
      if (!retreat && cnext > {1'b0, used_ff[depth_ff]}) retreat = 1'b1;
      bi  = JI'(depth_ff - 1'b1);
      bc  = choice_ff[bi];
      bu  = used_ff[bi];
      bwk = (bc == '0) ? WI'(bu) : WI'(bc - 1'b1);
      fwk = (cnext == '0) ? WI'(used_ff[depth_ff]) : WI'(cnext - 1'b1);
      fload = loads_ff[fwk] + LW'(jobs_ff[di]);
      same_n = (32'(count_ff) == 32'(wcnt));
      done_in = 1'b0;
      if (cmd == mmja_pkg::CMD_INIT) done_in = same_n;
      else if (cmd == mmja_pkg::CMD_STEP) done_in = !done_ff && retreat && depth_ff == '0;
   end

   assign status.sort_done   = sdone_ff;
   assign status.search_done = done_ff;
   assign result   = result_ff;
   assign overflow = overflow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; ovf_ff <= 1'b0; done_ff <= 1'b0; sdone_ff <= 1'b0;
         pass_ff <= '0; depth_ff <= '0; enter_ff <= 1'b1;
         best_ff <= '1;
      end else begin
         done_ff  <= done_in;
         sdone_ff <= (cmd == mmja_pkg::CMD_SORT) && (pass_ff >= count_ff);
         unique case (cmd)
            mmja_pkg::CMD_LOAD: begin
               if (32'(count_ff) < MAX_JOBS) begin
                  jobs_ff[JI'(count_ff)] <= job_in;
                  count_ff <= count_ff + 1'b1;
               end else begin
                  ovf_ff <= 1'b1;
               end
               pass_ff <= '0;
            end
            // One odd-even transposition pass per cycle, descending order.
            mmja_pkg::CMD_SORT: begin
               for (int k = 0; k + 1 < MAX_JOBS; k++) begin
                  if ((k % 2) == int'(pass_ff[0]) && (k + 1) < int'(count_ff)
                      && jobs_ff[k] < jobs_ff[k+1]) begin
                     jobs_ff[k]   <= jobs_ff[k+1];
                     jobs_ff[k+1] <= jobs_ff[k];
                  end
               end
               pass_ff <= pass_ff + 1'b1;
            end
            mmja_pkg::CMD_INIT: begin
               for (int k = 0; k < MAX_WORKERS; k++) loads_ff[k] <= '0;
               used_ff[0] <= '0; max_ff[0] <= '0;
               depth_ff <= '0; enter_ff <= 1'b1;
               // With one job per worker the answer is the largest job.
               best_ff <= same_n ? (LW+1)'(jobs_ff[0]) : '1;
            end
            mmja_pkg::CMD_STEP: begin
               if (done_ff) begin
               end else if (retreat) begin
                  if (enter_ff && at_leaf && {1'b0, max_ff[depth_ff]} < best_ff)
                     best_ff <= {1'b0, max_ff[depth_ff]};
                  if (depth_ff != '0) begin
                     loads_ff[bwk] <= loads_ff[bwk] - LW'(jobs_ff[bi]);
                     depth_ff <= depth_ff - 1'b1;
                     enter_ff <= 1'b0;
                  end
               end else begin
                  choice_ff[di] <= WW'(cnext);
                  loads_ff[fwk] <= fload;
                  used_ff[depth_ff+1'b1] <= (cnext == '0) ?
                     used_ff[depth_ff] + 1'b1 : used_ff[depth_ff];
                  max_ff[depth_ff+1'b1] <= (fload > max_ff[depth_ff]) ?
                     fload : max_ff[depth_ff];
                  depth_ff <= depth_ff + 1'b1;
                  enter_ff <= 1'b1;
               end
            end
            mmja_pkg::CMD_EMIT: begin
               result_ff   <= (best_ff > (LW+1)'({OB{1'b1}})) ? '1 : OB'(best_ff);
               overflow_ff <= ovf_ff;
               count_ff    <= '0;
               ovf_ff      <= 1'b0;
               depth_ff    <= '0;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== hdl/min_makespan_job_assignment_top.sv =====
// Min-makespan job assignment: loads one job per cycle while not stalled.
// After the last job transfer the odd-even sort runs, then setup, then the search, whose
// length depends on the tree steps taken, so latency is data dependent.
// The result register loads once the previous result has left; the
// input stalls from the last job transfer until then.
// Synchronous active-high reset clears the job count, flags and worker_count to 1.
`default_nettype none
`include "min_makespan_job_assignment_top_defines.svh"
module min_makespan_job_assignment_top #(
   parameter int MAX_JOBS    = mmja_pkg::MaxJobs,
   parameter int MAX_WORKERS = mmja_pkg::MaxWorkers,
   parameter int JOB_BITS    = mmja_pkg::JobBits
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write,
   input  wire logic [4:0]              csr_worker_count,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [JOB_BITS-1:0]     req_job_time,
   input  wire logic                    req_last_job,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [mmja_pkg::OutBits-1:0] rsp_min_makespan,
   output logic                         rsp_too_many_jobs
);
   logic [4:0]           workers_ff;
   mmja_pkg::cmd_type    cmd;
   mmja_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) workers_ff <= 5'd1;
      else if (csr_write) workers_ff <= csr_worker_count;
   end

   mmja_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_last_job, .req_stall,
      .rsp_valid, .rsp_stall, .status, .cmd
   );

   mmja_dp #(.MAX_JOBS(MAX_JOBS), .MAX_WORKERS(MAX_WORKERS), .JOB_BITS(JOB_BITS)) u_dp (
      .clock, .reset, .cmd, .job_in(req_job_time), .workers(workers_ff),
      .status, .result(rsp_min_makespan), .overflow(rsp_too_many_jobs)
   );

   `MMJA_ASSERT_IMPL(a_no_load_in_search, clock, reset,
      status.search_done, cmd != mmja_pkg::CMD_LOAD)
   `MMJA_ASSERT_NEXT(a_last_stalls, clock, reset,
      req_valid && !req_stall && req_last_job, req_stall)
endmodule
`default_nettype wire
